### rtl/fwrbv_pkg.sv
// shared types and constants for the fifo with remove-by-value
`timescale 1ns / 1ps
`default_nettype none

package fwrbv_pkg;

  // default sizes
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_OUT_W = 5;

  // command codes carried on s_axis_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_REM  = 2'd2,
    CMD_LIST = 2'd3
  } cmd_e;

  // result status carried on m_axis_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ENQ,
    CELL_SHIFT,
    CELL_MATCH,
    CELL_COMPACT,
    CELL_ROTATE
  } cell_op_e;

endpackage

`default_nettype wire

### rtl/fwrbv_cell.sv
// one storage cell of the compacting queue chain
`timescale 1ns / 1ps
`default_nettype none

module fwrbv_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned OCC_W       = 5,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  fwrbv_pkg::cell_op_e         op_i,
  input  wire  [OCC_W-1:0]            occ_i,
  input  wire  [VALUE_WIDTH-1:0]      value_i,
  input  wire  [VALUE_WIDTH-1:0]      nbr_i,
  input  wire  [VALUE_WIDTH-1:0]      head_i,
  input  wire                         found_i,
  output logic [VALUE_WIDTH-1:0]      value_o,
  output logic                        found_o
);
  import fwrbv_pkg::*;

  localparam logic [OCC_W-1:0] MY_IDX   = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] MY_IDX_1 = OCC_W'(IDX + 1);

  logic [VALUE_WIDTH-1:0] value_q;
  logic                   match_q;
  logic                   held;

  assign held    = (MY_IDX < occ_i);
  assign value_o = value_q;
  // a match here or closer to the head makes this cell pull from its neighbor
  assign found_o = found_i | match_q;

  // match flag, set while a removal searches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (op_i == CELL_MATCH) begin
      match_q <= held && (value_q == value_i);
    end
  end

  // entry value
  always_ff @(posedge clk_i) begin
    case (op_i)
      CELL_ENQ: begin
        if (occ_i == MY_IDX) value_q <= value_i;
      end
      CELL_SHIFT: begin
        value_q <= nbr_i;
      end
      CELL_COMPACT: begin
        if (found_i || match_q) value_q <= nbr_i;
      end
      CELL_ROTATE: begin
        value_q <= (occ_i == MY_IDX_1) ? head_i : nbr_i;
      end
      default: begin
        value_q <= value_q;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/fifo_with_remove_by_value_core.sv
// bounded fifo of signed values with enqueue, dequeue, remove-by-value and list
//
// Input items arrive on s_axis: s_axis_tuser holds the command (enqueue,
// dequeue, remove first match, list) and s_axis_tdata the value. Results
// leave on m_axis: m_axis_tdata holds the value and the occupancy after the
// operation, m_axis_tuser the status (ok, full, empty, not found), and
// m_axis_tlast marks the final result of an item.
// Entries sit in a chain of cells, slot 0 being the head; dequeue shifts the
// whole chain toward the head by one cell, removal only the cells behind the
// first match. Enqueue and dequeue are done at acceptance and their result is
// registered in the cycle after it. Remove first compares every held cell,
// then, once the output register is free, compacts behind the first match
// and registers the result. List starts and then rotates the chain once per
// emitted entry while the output register is free (an empty queue gives one
// empty result). A new item is taken only when no remove or list runs and
// the output register is empty or its result leaves in that same cycle.
// Reset empties the queue; entry contents are not cleared. When the
// receiver stalls, the output register holds and the chain waits with it.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_remove_by_value_core #(
  parameter int unsigned DEPTH       = fwrbv_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = fwrbv_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned S_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W  = ((VALUE_WIDTH + fwrbv_pkg::OCC_OUT_W + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [S_TDATA_W-1:0]             s_axis_tdata,  // value
  input  wire  [fwrbv_pkg::CMD_W-1:0]      s_axis_tuser,  // command
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [M_TDATA_W-1:0]             m_axis_tdata,  // value_out, occupancy_out
  output logic [fwrbv_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
  output logic                             m_axis_tlast   // last
);
  import fwrbv_pkg::*;

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_LIST
  } state_e;

  state_e                  state_q;
  logic [OCC_W-1:0]        occ_q;
  logic [OCC_W-1:0]        cnt_q;
  logic                    out_valid_q;
  logic [VALUE_WIDTH-1:0]  out_value_q;
  status_e                 out_status_q;
  logic                    out_last_q;
  logic [OCC_OUT_W-1:0]    out_occ_q;
  logic [VALUE_WIDTH-1:0]  key_q;

  logic                    out_free;
  logic                    accept;
  cmd_e                    cmd;
  logic [VALUE_WIDTH-1:0]  in_value;
  logic                    is_full;
  logic                    is_empty;
  cell_op_e                cell_op;
  logic [VALUE_WIDTH-1:0]  cell_val [DEPTH];
  logic                    found [DEPTH+1];
  logic                    list_last;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign in_value      = s_axis_tdata[VALUE_WIDTH-1:0];
  assign is_full       = (occ_q == OCC_FULL);
  assign is_empty      = (occ_q == '0);
  assign list_last     = (cnt_q == (occ_q - 1'b1));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_occ_q, out_value_q});
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // operation for the cell chain
  always_comb begin
    cell_op = CELL_HOLD;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ENQ:  cell_op = is_full  ? CELL_HOLD : CELL_ENQ;
            CMD_DEQ:  cell_op = is_empty ? CELL_HOLD : CELL_SHIFT;
            CMD_REM:  cell_op = CELL_MATCH;
            default:  cell_op = CELL_HOLD;
          endcase
        end
      end
      S_MATCH: begin
        if (out_free && found[DEPTH]) cell_op = CELL_COMPACT;
      end
      S_LIST: begin
        if (out_free) cell_op = CELL_ROTATE;
      end
      default: cell_op = CELL_HOLD;
    endcase
  end

  // chain of cells, head at index 0
  assign found[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] nbr;
    if (g == DEPTH - 1) begin : g_tail
      assign nbr = cell_val[g];
    end else begin : g_mid
      assign nbr = cell_val[g+1];
    end
    fwrbv_cell #(
      .IDX         (g),
      .OCC_W       (OCC_W),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .occ_i   (occ_q),
      .value_i (in_value),
      .nbr_i   (nbr),
      .head_i  (cell_val[0]),
      .found_i (found[g]),
      .value_o (cell_val[g]),
      .found_o (found[g+1])
    );
  end

  // sequencer, occupancy and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
      out_occ_q    <= '0;
      key_q        <= '0;
    end else begin
      if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_ENQ: begin
                out_valid_q <= 1'b1;
                out_value_q <= in_value;
                out_last_q  <= 1'b1;
                if (is_full) begin
                  out_status_q <= ST_FULL;
                  out_occ_q    <= OCC_OUT_W'(occ_q);
                end else begin
                  out_status_q <= ST_OK;
                  out_occ_q    <= OCC_OUT_W'(occ_q + 1'b1);
                  occ_q        <= occ_q + 1'b1;
                end
              end
              CMD_DEQ: begin
                out_valid_q <= 1'b1;
                out_last_q  <= 1'b1;
                if (is_empty) begin
                  out_value_q  <= '0;
                  out_status_q <= ST_EMPTY;
                  out_occ_q    <= OCC_OUT_W'(occ_q);
                end else begin
                  out_value_q  <= cell_val[0];
                  out_status_q <= ST_OK;
                  out_occ_q    <= OCC_OUT_W'(occ_q - 1'b1);
                  occ_q        <= occ_q - 1'b1;
                end
              end
              CMD_REM: begin
                key_q   <= in_value;
                state_q <= S_MATCH;
              end
              default: begin
                if (is_empty) begin
                  out_valid_q  <= 1'b1;
                  out_value_q  <= '0;
                  out_status_q <= ST_EMPTY;
                  out_last_q   <= 1'b1;
                  out_occ_q    <= '0;
                end else begin
                  cnt_q   <= '0;
                  state_q <= S_LIST;
                end
              end
            endcase
          end
        end
        S_MATCH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= key_q;
            out_last_q  <= 1'b1;
            if (found[DEPTH]) begin
              out_status_q <= ST_OK;
              out_occ_q    <= OCC_OUT_W'(occ_q - 1'b1);
              occ_q        <= occ_q - 1'b1;
            end else begin
              out_status_q <= ST_NOTFOUND;
              out_occ_q    <= OCC_OUT_W'(occ_q);
            end
            state_q <= S_IDLE;
          end
        end
        S_LIST: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= cell_val[0];
            out_status_q <= ST_OK;
            out_last_q   <= list_last;
            out_occ_q    <= OCC_OUT_W'(occ_q);
            cnt_q        <= cnt_q + 1'b1;
            if (list_last) state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy stays within the store
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_FULL)
    else $error("occupancy above depth");

  // an accepted enqueue into a non-full queue grows it by one
  a_enq_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_ENQ && !is_full) |=> occ_q == $past(occ_q) + 1'b1)
    else $error("enqueue did not grow occupancy");

  // a listing runs only over a non-empty queue and within it
  a_list_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |-> (occ_q != '0) && (cnt_q < occ_q))
    else $error("list counter out of range");

  // a result without last can only come from a listing in progress
  a_nonlast_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> state_q == S_LIST)
    else $error("non-final result outside a listing");

  // the occupancy does not change while a listing runs
  a_list_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST && $past(state_q) == S_LIST) |-> $stable(occ_q))
    else $error("occupancy changed during listing");

endmodule

`default_nettype wire
